// ----- hdl/stereo_fft_magnitude_spectrum_core_assert.svh -----
`ifndef STEREO_FFT_MAGNITUDE_SPECTRUM_CORE_ASSERT_SVH
`define STEREO_FFT_MAGNITUDE_SPECTRUM_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SFM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/sfm_pkg.sv -----
package sfm_pkg;
    localparam int MAX_POINTS = 128;
    localparam int WORD_W = 18;
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_WIN = 2'd1;
    localparam logic [1:0] OP_SPEC = 2'd2;

    // datapath commands
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_LOAD = 3'd1;
    localparam logic [2:0] CMD_BFLY = 3'd2;
    localparam logic [2:0] CMD_MAG = 3'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic       ch;
        logic [6:0] a;
        logic [6:0] b;
        logic [5:0] tw;
        logic [6:0] src;
        logic [5:0] bin;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_stat;

    function automatic logic [15:0] sine_q15(input logic [5:0] m);
        logic [15:0] r;
        case (m)
            6'd0: r = 16'd0; 6'd1: r = 16'd1608; 6'd2: r = 16'd3212;
            6'd3: r = 16'd4808; 6'd4: r = 16'd6393; 6'd5: r = 16'd7962;
            6'd6: r = 16'd9512; 6'd7: r = 16'd11039; 6'd8: r = 16'd12540;
            6'd9: r = 16'd14010; 6'd10: r = 16'd15447; 6'd11: r = 16'd16846;
            6'd12: r = 16'd18205; 6'd13: r = 16'd19520; 6'd14: r = 16'd20788;
            6'd15: r = 16'd22006; 6'd16: r = 16'd23170; 6'd17: r = 16'd24279;
            6'd18: r = 16'd25330; 6'd19: r = 16'd26320; 6'd20: r = 16'd27246;
            6'd21: r = 16'd28106; 6'd22: r = 16'd28899; 6'd23: r = 16'd29622;
            6'd24: r = 16'd30274; 6'd25: r = 16'd30853; 6'd26: r = 16'd31357;
            6'd27: r = 16'd31786; 6'd28: r = 16'd32138; 6'd29: r = 16'd32413;
            6'd30: r = 16'd32610; 6'd31: r = 16'd32729; 6'd32: r = 16'd32768;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [47:0] v);
        if (v > 48'sd131071) return 18'sd131071;
        if (v < -48'sd131072) return -18'sd131072;
        return v[WORD_W-1:0];
    endfunction
endpackage

// ----- hdl/sfm_ram.sv -----
module sfm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/sfm_ctrl.sv -----
// Sequencer: per spectrum a load sweep, FFT stages per channel, and a magnitude sweep.
// Each butterfly, each magnitude step and the end of the load sweep wait for the datapath to report idle.
module sfm_ctrl #(
    parameter int N = 128,
    parameter int BINS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [6:0]    i_oldest,
    input  sfm_pkg::t_stat i_stat,
    output sfm_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    localparam int LG = $clog2(N);
    localparam int NB = (BINS < N) ? BINS : N;
    localparam int SH0 = $clog2(sfm_pkg::MAX_POINTS) - LG;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_FFT = 3'd2;
    localparam logic [2:0] S_MAG = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_after, n_after;
    logic [7:0] r_i, n_i;
    logic [2:0] r_stg, n_stg;
    logic       r_ch, n_ch;
    sfm_pkg::t_cmd c;
    logic [6:0] h, jj, base, pa;
    logic [7:0] sum;
    logic [6:0] rev;

    always_comb begin
        h = 7'((N >> 1) >> r_stg);
        jj = r_i[6:0] & (h - 7'd1);
        base = 7'((r_i[6:0] & ~(h - 7'd1)) << 1);
        sum = 8'(i_oldest) + r_i;
        pa = (sum >= 8'(N)) ? 7'(sum - 8'(N)) : sum[6:0];
        rev = '0;
        for (int k = 0; k < LG; k++)
            if (r_i[k]) rev[LG-1-k] = 1'b1;
    end

    always_comb begin
        n_state = r_state; n_after = r_after; n_i = r_i; n_stg = r_stg; n_ch = r_ch;
        c = '0;
        c.ch = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOAD; n_i = '0;
                end
            end
            S_LOAD: begin
                c.cmd = sfm_pkg::CMD_LOAD; c.src = pa; c.a = r_i[6:0];
                n_i = r_i + 8'd1;
                if (r_i == 8'(N - 1)) begin
                    n_i = '0; n_stg = '0; n_ch = 1'b0; n_state = S_WAIT; n_after = S_FFT;
                end
            end
            S_FFT: begin
                c.cmd = sfm_pkg::CMD_BFLY;
                c.a = base + jj; c.b = base + jj + h;
                // twiddle step doubles with each stage
                c.tw = 6'({25'd0, jj} << (SH0 + 32'(r_stg)));
                n_state = S_WAIT; n_after = S_FFT;
                n_i = r_i + 8'd1;
                if (r_i == 8'(N / 2 - 1)) begin
                    n_i = '0;
                    n_stg = r_stg + 3'd1;
                    if (r_stg == 3'(LG - 1)) begin
                        n_stg = '0;
                        n_ch = ~r_ch;
                        if (r_ch) n_after = S_MAG;
                    end
                end
            end
            S_MAG: begin
                c.cmd = sfm_pkg::CMD_MAG; c.a = rev; c.bin = r_i[5:0];
                c.last = (r_i == 8'(NB - 1));
                n_state = S_WAIT; n_after = S_MAG;
                n_i = r_i + 8'd1;
                if (r_i == 8'(NB - 1)) n_after = S_IDLE;
            end
            S_WAIT: begin
                if (!i_stat.busy) n_state = r_after;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_after <= S_IDLE; r_i <= '0; r_stg <= '0; r_ch <= 1'b0;
        end else begin
            r_state <= n_state; r_after <= n_after; r_i <= n_i; r_stg <= n_stg; r_ch <= n_ch;
        end
    end

    assign o_cmd = c;
    assign o_busy = (r_state != S_IDLE);
endmodule

// ----- hdl/sfm_dp.sv -----
`include "stereo_fft_magnitude_spectrum_core_assert.svh"
// Datapath: frame ring, window store, two work memories, one shared butterfly and a
// bit-serial square root. Load issues one point per cycle through a short pipe;
// butterflies and magnitudes run as multi-cycle sequences.
module sfm_dp #(
    parameter int N = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic signed [15:0]  i_left,
    input  logic signed [15:0]  i_right,
    input  logic                i_wwr,
    input  logic [6:0]          i_widx,
    input  logic [15:0]         i_wval,
    input  sfm_pkg::t_cmd       i_cmd,
    output sfm_pkg::t_stat      o_stat,
    output logic [6:0]          o_oldest,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [5:0]          o_bin,
    output logic [15:0]         o_lmag,
    output logic [15:0]         o_rmag,
    output logic                o_last
);
    localparam int AW = $clog2(N);
    localparam int W = sfm_pkg::WORD_W;

    // ring/window memories, cleared by valid bits
    logic [N-1:0] r_rvld, r_wvld;
    logic [6:0] r_oldest;
    logic [31:0] ring_q;
    logic [15:0] win_q;
    logic [AW-1:0] ring_ra, win_ra;
    logic ring_ok, win_ok;

    sfm_ram #(.WIDTH(32), .DEPTH(N)) u_ring (
        .i_clk(i_clk), .i_we(i_push), .i_waddr(r_oldest[AW-1:0]),
        .i_wdata({i_right, i_left}), .i_raddr(ring_ra), .o_rdata(ring_q));
    sfm_ram #(.WIDTH(16), .DEPTH(N)) u_win (
        .i_clk(i_clk), .i_we(i_wwr && (32'(i_widx) < N)), .i_waddr(i_widx[AW-1:0]),
        .i_wdata(i_wval), .i_raddr(win_ra), .o_rdata(win_q));

    // work memories: channel 0 and 1, word {re, im}
    logic          wk_we [2];
    logic [AW-1:0] wk_wa [2];
    logic [2*W-1:0] wk_wd [2];
    logic [AW-1:0] wk_ra [2];
    logic [2*W-1:0] wk_q [2];
    for (genvar g = 0; g < 2; g++) begin : g_wk
        sfm_ram #(.WIDTH(2*W), .DEPTH(N)) u_wk (
            .i_clk(i_clk), .i_we(wk_we[g]), .i_waddr(wk_wa[g]), .i_wdata(wk_wd[g]),
            .i_raddr(wk_ra[g]), .o_rdata(wk_q[g]));
    end

    // load pipe
    logic r_l1, r_l2;
    logic [AW-1:0] r_la1, r_la2;
    logic r_rok, r_wok;
    logic signed [16:0] r_wv;
    logic signed [15:0] r_ls, r_rs;
    logic signed [33:0] r_pl, r_pr;
    logic r_l3;
    logic [AW-1:0] r_la3;

    // sequence unit
    localparam logic [3:0] Q_IDLE = 4'd0;
    localparam logic [3:0] Q_RDA = 4'd1;
    localparam logic [3:0] Q_RDB = 4'd2;
    localparam logic [3:0] Q_M1 = 4'd3;
    localparam logic [3:0] Q_M2 = 4'd4;
    localparam logic [3:0] Q_WR = 4'd5;
    localparam logic [3:0] Q_SQ = 4'd6;
    localparam logic [3:0] Q_OUT = 4'd7;
    localparam logic [3:0] Q_MRD = 4'd8;
    localparam logic [3:0] Q_MSQ = 4'd9;
    logic [3:0] r_q;
    logic r_ch, r_mag, r_mch;
    logic [AW-1:0] r_a, r_b;
    logic [5:0] r_tw, r_bin;
    logic r_lastf;
    logic signed [W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [W:0] r_dr, r_di;
    logic signed [16:0] r_wr, r_wi;
    logic signed [37:0] r_p0, r_p1, r_p2, r_p3;
    logic [36:0] r_v, r_root, r_bit;
    logic [5:0] r_cnt;
    logic [15:0] r_lm;
    logic r_ov;
    logic [5:0] r_ob;
    logic [15:0] r_ol, r_or;
    logic r_olast;

    logic [5:0] tm;
    logic signed [16:0] twr, twi;
    always_comb begin
        tm = r_tw;
        if (tm <= 6'd32) begin
            twr = 17'(sfm_pkg::sine_q15(6'd32 - tm));
            twi = -17'(sfm_pkg::sine_q15(tm));
        end else begin
            twr = -17'(sfm_pkg::sine_q15(tm - 6'd32));
            twi = -17'(sfm_pkg::sine_q15(6'd0 - tm));
        end
    end

    logic signed [47:0] sum_r, sum_i, bf_r, bf_i;
    logic [36:0] rb;
    always_comb begin
        sum_r = 48'(r_ar) + 48'(r_br) + 48'sd1;
        sum_i = 48'(r_ai) + 48'(r_bi) + 48'sd1;
        bf_r = 48'(r_p0) - 48'(r_p1) + 48'sd32768;
        bf_i = 48'(r_p2) + 48'(r_p3) + 48'sd32768;
        rb = r_root + r_bit;
    end

    always_comb begin
        ring_ra = i_cmd.src[AW-1:0];
        win_ra = i_cmd.a[AW-1:0];
        for (int g = 0; g < 2; g++) begin
            wk_we[g] = 1'b0; wk_wa[g] = r_la3; wk_wd[g] = '0; wk_ra[g] = r_a;
        end
        if (r_l3) begin
            wk_we[0] = 1'b1;
            wk_wd[0] = {sfm_pkg::sat_word(48'(r_pl + 34'sd16384) >>> 15), W'(0)};
            wk_we[1] = 1'b1;
            wk_wd[1] = {sfm_pkg::sat_word(48'(r_pr + 34'sd16384) >>> 15), W'(0)};
        end
        // point a is read first, point b in the following cycle
        if (r_q == Q_RDB) wk_ra[r_ch] = r_b;
        if (r_q == Q_WR) begin
            wk_we[r_ch] = 1'b1; wk_wa[r_ch] = r_a;
            wk_wd[r_ch] = {sfm_pkg::sat_word(sum_r >>> 1), sfm_pkg::sat_word(sum_i >>> 1)};
        end
        if (r_q == Q_SQ) begin
            wk_we[r_ch] = 1'b1; wk_wa[r_ch] = r_b;
            wk_wd[r_ch] = {sfm_pkg::sat_word(bf_r >>> 16), sfm_pkg::sat_word(bf_i >>> 16)};
        end
    end
    assign ring_ok = 1'b1;
    assign win_ok = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= '0; r_wvld <= '0; r_oldest <= '0;
            r_l1 <= 1'b0; r_l2 <= 1'b0; r_l3 <= 1'b0;
            r_q <= Q_IDLE; r_ov <= 1'b0;
        end else begin
            if (i_push) begin
                r_rvld[r_oldest[AW-1:0]] <= 1'b1;
                r_oldest <= (32'(r_oldest) == N - 1) ? 7'd0 : r_oldest + 7'd1;
            end
            if (i_wwr && (32'(i_widx) < N)) r_wvld[i_widx[AW-1:0]] <= 1'b1;
            if (r_ov && i_ready && (r_q != Q_OUT)) r_ov <= 1'b0;
            r_l1 <= (i_cmd.cmd == sfm_pkg::CMD_LOAD);
            r_la1 <= i_cmd.a[AW-1:0];
            r_rok <= r_rvld[ring_ra] && ring_ok;
            r_wok <= r_wvld[win_ra] && win_ok;
            r_l2 <= r_l1; r_la2 <= r_la1;
            r_ls <= r_rok ? ring_q[15:0] : 16'sd0;
            r_rs <= r_rok ? ring_q[31:16] : 16'sd0;
            r_wv <= r_wok ? 17'(win_q) : 17'sd0;
            r_l3 <= r_l2; r_la3 <= r_la2;
            r_pl <= 34'(r_ls) * 34'(r_wv);
            r_pr <= 34'(r_rs) * 34'(r_wv);
            unique case (r_q)
                Q_IDLE: begin
                    r_ch <= i_cmd.ch; r_a <= i_cmd.a[AW-1:0]; r_b <= i_cmd.b[AW-1:0];
                    r_tw <= i_cmd.tw; r_bin <= i_cmd.bin; r_lastf <= i_cmd.last;
                    if (i_cmd.cmd == sfm_pkg::CMD_BFLY) r_q <= Q_RDA;
                    if (i_cmd.cmd == sfm_pkg::CMD_MAG) begin
                        r_q <= Q_MRD; r_mch <= 1'b0; r_mag <= 1'b1;
                    end
                end
                Q_RDA: r_q <= Q_RDB;
                Q_RDB: begin
                    r_ar <= wk_q[r_ch][2*W-1:W]; r_ai <= wk_q[r_ch][W-1:0];
                    r_q <= Q_M1;
                end
                Q_M1: begin
                    r_br <= wk_q[r_ch][2*W-1:W]; r_bi <= wk_q[r_ch][W-1:0];
                    r_dr <= (W+1)'(r_ar) - (W+1)'($signed(wk_q[r_ch][2*W-1:W]));
                    r_di <= (W+1)'(r_ai) - (W+1)'($signed(wk_q[r_ch][W-1:0]));
                    r_wr <= twr; r_wi <= twi;
                    r_q <= Q_M2;
                end
                Q_M2: begin
                    r_p0 <= 38'(r_dr) * 38'(r_wr); r_p1 <= 38'(r_di) * 38'(r_wi);
                    r_p2 <= 38'(r_dr) * 38'(r_wi); r_p3 <= 38'(r_di) * 38'(r_wr);
                    r_q <= Q_WR;
                end
                Q_WR: r_q <= Q_SQ;
                Q_SQ: r_q <= Q_IDLE;
                Q_MRD: begin
                    r_q <= Q_MSQ; r_cnt <= 6'd0;
                end
                Q_MSQ: begin
                    if (r_cnt == 6'd0) begin
                        r_p0 <= 38'($signed(wk_q[r_mch][2*W-1:W])) *
                                38'($signed(wk_q[r_mch][2*W-1:W]));
                        r_p1 <= 38'($signed(wk_q[r_mch][W-1:0])) *
                                38'($signed(wk_q[r_mch][W-1:0]));
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd1) begin
                        r_v <= 37'(r_p0) + 37'(r_p1);
                        r_root <= '0; r_bit <= 37'(1) << 36;
                        r_cnt <= 6'd2;
                    end else if (r_bit != '0) begin
                        if (r_v >= rb) begin
                            r_v <= r_v - rb; r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        if (!r_mch) begin
                            r_lm <= (r_root > 37'd32768) ? 16'h8000 : r_root[15:0];
                            r_mch <= 1'b1; r_q <= Q_MRD;
                        end else begin
                            r_q <= Q_OUT;
                        end
                    end
                end
                Q_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov <= 1'b1; r_ob <= r_bin; r_ol <= r_lm;
                        r_or <= (r_root > 37'd32768) ? 16'h8000 : r_root[15:0];
                        r_olast <= r_lastf; r_q <= Q_IDLE; r_mag <= 1'b0;
                    end
                end
                default: r_q <= Q_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_q != Q_IDLE) || r_l1 || r_l2 || r_l3 || (i_cmd.cmd != sfm_pkg::CMD_NONE);
    assign o_oldest = r_oldest;
    assign o_valid = r_ov;
    assign o_bin = r_ob;
    assign o_lmag = r_ol;
    assign o_rmag = r_or;
    assign o_last = r_olast;

    `SFM_ASSERT_IMP(a_no_wr_clash, i_clk, i_rst_n, r_l3, (r_q != Q_WR) && (r_q != Q_SQ),
        "load write collides with butterfly write")
    `SFM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_ob),
        "result dropped while stalled")
    `SFM_ASSERT_IMP(a_mag_mode, i_clk, i_rst_n, r_q == Q_OUT, r_mag,
        "output stage reached outside magnitude sweep")
endmodule

// ----- hdl/stereo_fft_magnitude_spectrum_core.sv -----
// Push (op 0) and window write (op 1) complete when accepted.
// Spectrum (op 2): a load sweep, then per channel log2(N)*N/2 butterflies, then per bin
// two square roots in turn; the sweep waits while an earlier result is still held.
// Input is not taken while a spectrum is in progress or a result waits.
// Synchronous active-low reset; ring and window read as zero until written.
module stereo_fft_magnitude_spectrum_core #(
    parameter int FFT_POINTS = 128,
    parameter int RESULT_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // left_sample, right_sample, window_index, window_value
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // bin_index, left_magnitude, right_magnitude
    output logic        m_axis_tlast
);
    logic acc, busy, start;
    logic [6:0] oldest;
    sfm_pkg::t_cmd cmd;
    sfm_pkg::t_stat stat;

    assign s_axis_tready = !busy && !m_axis_tvalid;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign start = acc && (s_axis_tuser == sfm_pkg::OP_SPEC);

    sfm_ctrl #(.N(FFT_POINTS), .BINS(RESULT_BINS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_oldest(oldest),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy));

    sfm_dp #(.N(FFT_POINTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(acc && (s_axis_tuser == sfm_pkg::OP_PUSH)),
        .i_left(s_axis_tdata[15:0]), .i_right(s_axis_tdata[31:16]),
        .i_wwr(acc && (s_axis_tuser == sfm_pkg::OP_WIN)),
        .i_widx(s_axis_tdata[38:32]), .i_wval(s_axis_tdata[54:39]),
        .i_cmd(cmd), .o_stat(stat), .o_oldest(oldest),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_bin(m_axis_tdata[5:0]), .o_lmag(m_axis_tdata[21:6]),
        .o_rmag(m_axis_tdata[37:22]), .o_last(m_axis_tlast));
    assign m_axis_tdata[39:38] = 2'b00;
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    localparam int NPTS = 128;
    localparam int NBINS = 64;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int PHASE_IDLE [4] = '{0, 54, 0, 27};
    localparam int PHASE_STALL [4] = '{0, 0, 54, 27};

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] left_s;
        logic signed [15:0] right_s;
        logic [6:0]         win_idx;
        logic [15:0]        win_val;
    } t_request;

    typedef struct packed {
        logic [5:0]  bin;
        logic [15:0] left_mag;
        logic [15:0] right_mag;
        logic        last;
    } t_bin;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    stereo_fft_magnitude_spectrum_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // spectrum model state
    logic [15:0] left_ring [NPTS];
    logic [15:0] right_ring [NPTS];
    logic [15:0] win_table [NPTS];
    int          oldest;

    t_request pending_q[$];
    t_bin     bin_q[$];
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       errors = 0;
    int       bins_seen = 0;
    int       spectra = 0;
    int       quiet_cycles = 0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint root = 0;
        longint bitv = 64'sd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint sine_tab(int m);
        int s[33] = '{0, 1608, 3212, 4808, 6393, 7962, 9512, 11039, 12540,
                      14010, 15447, 16846, 18205, 19520, 20788, 22006, 23170,
                      24279, 25330, 26320, 27246, 28106, 28899, 29622, 30274,
                      30853, 31357, 31786, 32138, 32413, 32610, 32729, 32768};
        return s[m];
    endfunction

    task automatic fft_channel(inout longint re[NPTS], inout longint im[NPTS]);
        int a, b, step;
        int m;
        longint wr, wi, dr, di;
        for (int h = NPTS / 2; h >= 1; h = h / 2) begin
            step = NPTS / (2 * h);
            for (int base = 0; base < NPTS; base += 2 * h) begin
                for (int j = 0; j < h; j++) begin
                    a = base + j;
                    b = base + j + h;
                    m = (j * step) & 63;
                    if (m <= 32) begin
                        wr = sine_tab(32 - m);
                        wi = -sine_tab(m);
                    end else begin
                        wr = -sine_tab(m - 32);
                        wi = -sine_tab(64 - m);
                    end
                    dr = re[a] - re[b];
                    di = im[a] - im[b];
                    re[a] = clamp18(floor_sh(re[a] + re[b] + 1, 1));
                    im[a] = clamp18(floor_sh(im[a] + im[b] + 1, 1));
                    re[b] = clamp18(floor_sh(dr * wr - di * wi + 32768, 16));
                    im[b] = clamp18(floor_sh(dr * wi + di * wr + 32768, 16));
                end
            end
        end
    endtask

    task automatic predict_spectrum(t_request rq);
        longint lre[NPTS], lim[NPTS], rre[NPTS], rim[NPTS];
        int p, r;
        longint w, lm, rm;
        t_bin e;
        case (rq.op)
            sfm_pkg::OP_PUSH: begin
                left_ring[oldest] = rq.left_s;
                right_ring[oldest] = rq.right_s;
                oldest = (oldest + 1) % NPTS;
            end
            sfm_pkg::OP_WIN: win_table[rq.win_idx] = rq.win_val;
            sfm_pkg::OP_SPEC: begin
                for (int i = 0; i < NPTS; i++) begin
                    p = (oldest + i) % NPTS;
                    w = win_table[i];
                    lre[i] = clamp18(floor_sh(longint'($signed(left_ring[p])) * w + 16384, 15));
                    rre[i] = clamp18(floor_sh(longint'($signed(right_ring[p])) * w + 16384, 15));
                    lim[i] = 0;
                    rim[i] = 0;
                end
                fft_channel(lre, lim);
                fft_channel(rre, rim);
                for (int i = 0; i < NBINS; i++) begin
                    r = 0;
                    for (int k = 0; k < 7; k++)
                        if (i & (1 << k)) r |= 1 << (6 - k);
                    lm = int_sqrt(lre[r] * lre[r] + lim[r] * lim[r]);
                    rm = int_sqrt(rre[r] * rre[r] + rim[r] * rim[r]);
                    e.bin = 6'(i);
                    e.left_mag = lm > 32768 ? 16'd32768 : lm[15:0];
                    e.right_mag = rm > 32768 ? 16'd32768 : rm[15:0];
                    e.last = (i == NBINS - 1);
                    bin_q.push_back(e);
                end
                spectra++;
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_spectrum(t_request'({s_axis_tuser,
                s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[38:32],
                s_axis_tdata[54:39]}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_request rq;
                    rq = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= rq.op;
                    s_axis_tdata <= {1'b0, rq.win_val, rq.win_idx, rq.right_s, rq.left_s};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                t_bin got, want;
                got = {m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tdata[37:22], m_axis_tlast};
                bins_seen++;
                if (bin_q.size() == 0) begin
                    $display("%0t: unexpected bin %0d", $time, got.bin);
                    errors++;
                end else begin
                    want = bin_q.pop_front();
                    if (got.bin !== want.bin)
                        $display("%0t: bin_index exp %0d got %0d", $time, want.bin, got.bin);
                    if (got.left_mag !== want.left_mag)
                        $display("%0t: bin %0d left exp %0d got %0d", $time, want.bin,
                                 want.left_mag, got.left_mag);
                    if (got.right_mag !== want.right_mag)
                        $display("%0t: bin %0d right exp %0d got %0d", $time, want.bin,
                                 want.right_mag, got.right_mag);
                    if (got.last !== want.last)
                        $display("%0t: bin %0d last exp %0b got %0b", $time, want.bin,
                                 want.last, got.last);
                    if (got !== want) errors++;
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("stereo_fft_magnitude_spectrum_core test failed");
                $finish;
            end
        end
    end

    function automatic t_request make_req(logic [1:0] op, int ls, int rs, int wi, int wv);
        t_request rq;
        rq.op = op;
        rq.left_s = 16'(ls);
        rq.right_s = 16'(rs);
        rq.win_idx = 7'(wi);
        rq.win_val = 16'(wv);
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid || bin_q.size() > 0) @(posedge i_clk);
    endtask

    // random sequence: mostly frame pushes, a few window writes and unused ops, then a spectrum
    task automatic add_random_block(int n_items);
        int k;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            if (k < 70)
                pending_q.push_back(make_req(sfm_pkg::OP_PUSH, $urandom, $urandom, 0, 0));
            else if (k < 92)
                pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, $urandom_range(127),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(32768)));
            else
                pending_q.push_back(make_req(OP_UNUSED, $urandom, $urandom, $urandom,
                    $urandom));
        end
        pending_q.push_back(make_req(sfm_pkg::OP_SPEC, $urandom, $urandom, $urandom,
            $urandom));
    endtask

    initial begin
        for (int i = 0; i < NPTS; i++) begin
            left_ring[i] = '0;
            right_ring[i] = '0;
            win_table[i] = '0;
        end
        oldest = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: spectrum of an all-zero state, extremes, unused op, big window
        pending_q.push_back(make_req(sfm_pkg::OP_SPEC, 0, 0, 0, 0));
        pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, 0, 32768));
        pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, 127, 65535));
        pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, 64, 32768));
        pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, 1, 0));
        pending_q.push_back(make_req(sfm_pkg::OP_PUSH, 32767, -32768, 0, 0));
        pending_q.push_back(make_req(sfm_pkg::OP_PUSH, -32768, 32767, 127, 65535));
        pending_q.push_back(make_req(sfm_pkg::OP_PUSH, -1, 0, 0, 0));
        pending_q.push_back(make_req(OP_UNUSED, -1, -1, 127, 65535));
        pending_q.push_back(make_req(sfm_pkg::OP_SPEC, 0, 0, 0, 0));
        for (int i = 0; i < NPTS; i++)
            pending_q.push_back(make_req(sfm_pkg::OP_WIN, 0, 0, i, 65535));
        for (int i = 0; i < 4; i++)
            pending_q.push_back(make_req(sfm_pkg::OP_PUSH, (i & 1) ? 32767 : -32768,
                                         (i & 1) ? -32768 : 32767, 0, 0));
        pending_q.push_back(make_req(sfm_pkg::OP_SPEC, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = PHASE_IDLE[ph];
            stall_pct = PHASE_STALL[ph];
            for (int b = 0; b < 3; b++) add_random_block($urandom_range(15, 40));
            wait_drained();
        end
        repeat (200) @(posedge i_clk);

        $display("Ran %0d spectra, %0d bins checked, over four idle/stall phases",
                 spectra, bins_seen);
        if (errors == 0 && bin_q.size() == 0) begin
            $display("stereo_fft_magnitude_spectrum_core test passed");
        end else begin
            $display("stereo_fft_magnitude_spectrum_core test failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sfm_pkg.sv
hdl/sfm_ram.sv
hdl/sfm_ctrl.sv
hdl/sfm_dp.sv
hdl/stereo_fft_magnitude_spectrum_core.sv
tb/sv/tb_top.sv
